// ----- hdl/wsf_pkg.sv -----
// Shared types, constants and conversion functions for the WAV stream decoder.
// Depends on nothing; used by the result queue and the top level.
package wsf_pkg;

  // Channel count limit for the fmt check.
  localparam int MAX_CHANNELS = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [3:0] ERR_TOO_SMALL = 4'd0;
  localparam logic [3:0] ERR_MAGIC = 4'd1;
  localparam logic [3:0] ERR_CHUNK_SIZE = 4'd2;
  localparam logic [3:0] ERR_FMT_SHORT = 4'd3;
  localparam logic [3:0] ERR_CHANNELS = 4'd4;
  localparam logic [3:0] ERR_MISSING = 4'd5;
  localparam logic [3:0] ERR_UNSUPPORTED = 4'd6;
  localparam logic [3:0] ERR_DATA_SIZE = 4'd7;
  localparam logic [3:0] ERR_FRAMES = 4'd8;
  localparam logic [3:0] ERR_DATA_FIRST = 4'd9;

  // Tags as little-endian words: byte 0 of the file sits in bits 7:0.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [31:0] FLOAT_PLUS_ONE = 32'h3F80_0000;
  localparam logic [31:0] FLOAT_MINUS_ONE = 32'hBF80_0000;
  localparam logic [30:0] FLOAT_INF_MAG = 31'h7F80_0000;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] sample_bits;
    logic sample_channel;
    logic [31:0] sample_rate;
    logic [1:0] channel_count;
    logic [3:0] error_code;
    logic last;
  } result_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  typedef struct packed {
    logic [QUEUE_AW:0] count;
    logic room;
  } queue_stat_t;

  function automatic logic [31:0] set_byte(logic [31:0] field, logic [1:0] pos, logic [7:0] b);
    logic [31:0] r;
    r = field;
    r[pos*8 +: 8] = b;
    return r;
  endfunction

  function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] pos);
    return tag[pos*8 +: 8];
  endfunction

  // Exact value / 32768 for a signed 16-bit sample.
  function automatic logic [31:0] pcm16_to_float(logic [15:0] raw);
    logic sgn;
    logic [15:0] mag;
    logic [3:0] p;
    logic [38:0] sh;
    logic [31:0] r;
    sgn = raw[15];
    mag = sgn ? 16'(~raw + 16'd1) : raw;
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) p = 4'(i);
    end
    sh = {23'd0, mag} << (5'd23 - {1'b0, p});
    if (mag == 16'd0) r = 32'd0;
    else r = {sgn, 8'(8'd112 + {4'd0, p}), sh[22:0]};
    return r;
  endfunction

  // Clamp to [-1, 1]; NaN passes unchanged.
  function automatic logic [31:0] float_clamp(logic [31:0] bits);
    logic [31:0] r;
    r = bits;
    if (bits[30:0] > FLOAT_PLUS_ONE[30:0] && bits[30:0] <= FLOAT_INF_MAG) begin
      r = bits[31] ? FLOAT_MINUS_ONE : FLOAT_PLUS_ONE;
    end
    return r;
  endfunction

endpackage

// ----- hdl/wav_stream_to_float_samples.sv -----
// Top level of the WAV stream decoder: header and chunk parser plus sample conversion.
// Depends on wsf_pkg and wsf_result_queue.
//
// Usage: the input channel (in_valid/in_ready) carries one file byte per transaction,
// with end_of_file high on the last byte. The output channel (out_valid/out_ready)
// carries results: one format result when a usable data chunk starts, one sample
// per 2 (PCM16) or 4 (Float32) data bytes, then done or an error code.
// Each byte is decoded in the cycle it is accepted, and its results (at most two)
// enter a four-entry result queue; the first reaches its head next cycle if it was empty.
// Throughput is one byte per cycle while the receiver keeps up. in_ready drops
// only when the queue cannot hold two more results, so a stalled receiver holds
// back the input once three or more results are queued.
// A byte with end_of_file returns the parser to its reset state after its results.
// Reset (rst, synchronous) empties the queue and restarts the header parse.
// Bytes after done or an error are consumed without results until end_of_file.
module wav_stream_to_float_samples (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] sample_bits,
  output logic        sample_channel,
  output logic [31:0] sample_rate,
  output logic [1:0]  channel_count,
  output logic [3:0]  error_code,
  output logic        last
);
  import wsf_pkg::*;

  typedef enum logic [5:0] {
    PH_HDR  = 6'b000001,
    PH_CHDR = 6'b000010,
    PH_FMT  = 6'b000100,
    PH_SKIP = 6'b001000,
    PH_DATA = 6'b010000,
    PH_HALT = 6'b100000
  } phase_t;

  phase_t phase, phase_next;
  logic [31:0] byte_in_field, byte_in_field_next;
  logic [31:0] chunk_id, chunk_id_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] bits_seen, bits_seen_next;
  logic found_format, found_format_next;
  logic [31:0] sample_assembly, sample_assembly_next;
  logic frame_position, frame_position_next;
  logic pad_pending, pad_pending_next;
  logic magic_bad, magic_bad_next;

  logic accept;
  logic a_valid, b_valid;
  logic [1:0] a_kind, b_kind;
  logic [31:0] a_bits;
  logic a_chan;
  logic [3:0] b_err;
  logic [31:0] bif_inc;
  logic is_pcm, is_float;
  logic [3:0] chk_code;
  logic chk_ok;
  logic [1:0] k_pos;
  logic [31:0] len_chk;

  result_t res_a, res_b, data0, data1, head;
  push_t push;
  queue_stat_t qstat;

  assign accept = in_valid && in_ready;
  assign in_ready = qstat.room;

  // Format check against a given data length.
  always_comb begin
    is_pcm = (format_tag == FMT_PCM) && (bits_seen == 16'd16);
    is_float = (format_tag == FMT_FLOAT) && (bits_seen == 16'd32);
    chk_ok = 1'b0;
    chk_code = ERR_UNSUPPORTED;
    if (is_pcm || is_float) begin
      if (is_pcm ? len_chk[0] : (len_chk[1:0] != 2'd0)) chk_code = ERR_DATA_SIZE;
      else if (channels_seen == 16'd0) chk_code = ERR_FRAMES;
      else if (channels_seen != 16'd1 && (is_pcm ? len_chk[1] : len_chk[2]))
        chk_code = ERR_FRAMES;
      else chk_ok = 1'b1;
    end
  end

  always_comb begin
    phase_next = phase;
    byte_in_field_next = byte_in_field;
    chunk_id_next = chunk_id;
    chunk_length_next = chunk_length;
    format_tag_next = format_tag;
    channels_seen_next = channels_seen;
    rate_seen_next = rate_seen;
    bits_seen_next = bits_seen;
    found_format_next = found_format;
    sample_assembly_next = sample_assembly;
    frame_position_next = frame_position;
    pad_pending_next = pad_pending;
    magic_bad_next = magic_bad;
    a_valid = 1'b0;
    a_kind = KIND_SAMPLE;
    a_bits = 32'd0;
    a_chan = 1'b0;
    b_valid = 1'b0;
    b_kind = KIND_ERROR;
    b_err = ERR_TOO_SMALL;
    bif_inc = byte_in_field + 32'd1;
    len_chk = chunk_length;
    k_pos = byte_in_field[1:0];

    case (phase)
      PH_HDR: begin
        if (byte_in_field < 32'd4 && in_byte != tag_byte(TAG_RIFF, byte_in_field[1:0]))
          magic_bad_next = 1'b1;
        if (byte_in_field >= 32'd8 && byte_in_field < 32'd12
            && in_byte != tag_byte(TAG_WAVE, byte_in_field[1:0]))
          magic_bad_next = 1'b1;
        byte_in_field_next = bif_inc;
        if (bif_inc < 32'd12) begin
          if (end_of_file) begin
            b_valid = 1'b1;
            b_err = ERR_TOO_SMALL;
          end
        end else if (magic_bad_next) begin
          b_valid = 1'b1;
          b_err = ERR_MAGIC;
        end else begin
          phase_next = PH_CHDR;
          byte_in_field_next = 32'd0;
          chunk_id_next = 32'd0;
          chunk_length_next = 32'd0;
          pad_pending_next = 1'b0;
          if (end_of_file) begin
            b_valid = 1'b1;
            b_err = ERR_MISSING;
          end
        end
      end
      PH_CHDR: begin
        if (pad_pending) begin
          pad_pending_next = 1'b0;
          if (end_of_file) begin
            b_valid = 1'b1;
            b_err = ERR_MISSING;
          end
        end else begin
          if (byte_in_field < 32'd4) chunk_id_next = set_byte(chunk_id, k_pos, in_byte);
          else chunk_length_next = set_byte(chunk_length, k_pos, in_byte);
          len_chk = chunk_length_next;
          byte_in_field_next = bif_inc;
          if (bif_inc < 32'd8) begin
            if (end_of_file) begin
              b_valid = 1'b1;
              b_err = ERR_MISSING;
            end
          end else begin
            byte_in_field_next = 32'd0;
            if (chunk_id_next == ID_DATA) begin
              if (!found_format) begin
                b_valid = 1'b1;
                b_err = ERR_DATA_FIRST;
              end else if (end_of_file && chunk_length_next != 32'd0) begin
                b_valid = 1'b1;
                b_err = ERR_CHUNK_SIZE;
              end else begin
                phase_next = PH_DATA;
                frame_position_next = 1'b0;
                sample_assembly_next = 32'd0;
                if (chk_ok) begin
                  a_valid = 1'b1;
                  a_kind = KIND_FORMAT;
                end
                if (chunk_length_next == 32'd0) begin
                  b_valid = 1'b1;
                  b_kind = chk_ok ? KIND_DONE : KIND_ERROR;
                  b_err = chk_ok ? ERR_TOO_SMALL : chk_code;
                end
              end
            end else begin
              phase_next = (chunk_id_next == ID_FMT) ? PH_FMT : PH_SKIP;
              if (chunk_length_next == 32'd0) begin
                // An empty fmt chunk is always too short.
                if (chunk_id_next == ID_FMT) begin
                  b_valid = 1'b1;
                  b_err = ERR_FMT_SHORT;
                end else begin
                  phase_next = PH_CHDR;
                  pad_pending_next = 1'b0;
                  chunk_id_next = 32'd0;
                  chunk_length_next = 32'd0;
                  if (end_of_file) begin
                    b_valid = 1'b1;
                    b_err = ERR_MISSING;
                  end
                end
              end else if (end_of_file) begin
                b_valid = 1'b1;
                b_err = ERR_CHUNK_SIZE;
              end
            end
          end
        end
      end
      PH_FMT, PH_SKIP: begin
        if (phase == PH_FMT && byte_in_field < 32'd16) begin
          if (byte_in_field < 32'd2) format_tag_next = 16'(set_byte(32'(format_tag), k_pos, in_byte));
          else if (byte_in_field < 32'd4)
            channels_seen_next = 16'(set_byte(32'(channels_seen), 2'(k_pos - 2'd2), in_byte));
          else if (byte_in_field < 32'd8) rate_seen_next = set_byte(rate_seen, k_pos, in_byte);
          else if (byte_in_field >= 32'd14)
            bits_seen_next = 16'(set_byte(32'(bits_seen), 2'(k_pos - 2'd2), in_byte));
        end
        byte_in_field_next = bif_inc;
        if (bif_inc == chunk_length) begin
          if (phase == PH_FMT && chunk_length < 32'd16) begin
            b_valid = 1'b1;
            b_err = ERR_FMT_SHORT;
          end else if (phase == PH_FMT && (channels_seen_next < 16'd1
                       || channels_seen_next > 16'(MAX_CHANNELS))) begin
            b_valid = 1'b1;
            b_err = ERR_CHANNELS;
          end else begin
            if (phase == PH_FMT) found_format_next = 1'b1;
            pad_pending_next = chunk_length[0];
            phase_next = PH_CHDR;
            byte_in_field_next = 32'd0;
            chunk_id_next = 32'd0;
            chunk_length_next = 32'd0;
            if (end_of_file) begin
              b_valid = 1'b1;
              b_err = ERR_MISSING;
            end
          end
        end else if (end_of_file) begin
          b_valid = 1'b1;
          b_err = ERR_CHUNK_SIZE;
        end
      end
      PH_DATA: begin
        if (chk_ok) begin
          if (is_pcm) k_pos = {1'b0, byte_in_field[0]};
          sample_assembly_next = set_byte(sample_assembly, k_pos, in_byte);
          if (is_pcm ? k_pos[0] : (k_pos == 2'd3)) begin
            a_valid = 1'b1;
            a_kind = KIND_SAMPLE;
            a_chan = frame_position;
            a_bits = is_pcm ? pcm16_to_float(sample_assembly_next[15:0])
                            : float_clamp(sample_assembly_next);
            frame_position_next = (channels_seen == 16'd1) ? 1'b0 : ~frame_position;
            sample_assembly_next = 32'd0;
          end
        end
        byte_in_field_next = bif_inc;
        if (bif_inc == chunk_length) begin
          b_valid = 1'b1;
          b_kind = chk_ok ? KIND_DONE : KIND_ERROR;
          b_err = chk_ok ? ERR_TOO_SMALL : chk_code;
        end else if (end_of_file) begin
          b_valid = 1'b1;
          b_err = ERR_CHUNK_SIZE;
        end
      end
      default: ;
    endcase

    if (b_valid) phase_next = PH_HALT;
  end

  always_comb begin
    res_a.kind = a_kind;
    res_a.sample_bits = a_bits;
    res_a.sample_channel = a_chan;
    res_a.sample_rate = rate_seen_next;
    res_a.channel_count = channels_seen_next[1:0];
    res_a.error_code = ERR_TOO_SMALL;
    res_a.last = !b_valid;
    res_b.kind = b_kind;
    res_b.sample_bits = 32'd0;
    res_b.sample_channel = 1'b0;
    res_b.sample_rate = rate_seen_next;
    res_b.channel_count = channels_seen_next[1:0];
    res_b.error_code = (b_kind == KIND_ERROR) ? b_err : ERR_TOO_SMALL;
    res_b.last = 1'b1;
    data0 = a_valid ? res_a : res_b;
    data1 = res_b;
    push.push0 = accept && (a_valid || b_valid);
    push.push1 = accept && a_valid && b_valid;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_file)) begin
      phase <= PH_HDR;
      byte_in_field <= '0;
      chunk_id <= '0;
      chunk_length <= '0;
      format_tag <= '0;
      channels_seen <= '0;
      rate_seen <= '0;
      bits_seen <= '0;
      found_format <= 1'b0;
      sample_assembly <= '0;
      frame_position <= 1'b0;
      pad_pending <= 1'b0;
      magic_bad <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      byte_in_field <= byte_in_field_next;
      chunk_id <= chunk_id_next;
      chunk_length <= chunk_length_next;
      format_tag <= format_tag_next;
      channels_seen <= channels_seen_next;
      rate_seen <= rate_seen_next;
      bits_seen <= bits_seen_next;
      found_format <= found_format_next;
      sample_assembly <= sample_assembly_next;
      frame_position <= frame_position_next;
      pad_pending <= pad_pending_next;
      magic_bad <= magic_bad_next;
    end
  end

  wsf_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .data0    (data0),
    .data1    (data1),
    .stat     (qstat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign kind = head.kind;
  assign sample_bits = head.sample_bits;
  assign sample_channel = head.sample_channel;
  assign sample_rate = head.sample_rate;
  assign channel_count = head.channel_count;
  assign error_code = head.error_code;
  assign last = head.last;

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("parser phase is not one-hot");

  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_file |=> phase == PH_HDR && byte_in_field == 32'd0)
    else $error("end of file did not restart the parser");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_HALT |-> !push.push0)
    else $error("result produced after done or error");

endmodule

// ----- hdl/wsf_result_queue.sv -----
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on wsf_pkg for the result and status types.
module wsf_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  wsf_pkg::push_t       push,
  input  wsf_pkg::result_t     data0,
  input  wsf_pkg::result_t     data1,
  output wsf_pkg::queue_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsf_pkg::result_t     head
);
  import wsf_pkg::*;

  result_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0] count;
  logic pop;
  logic [1:0] n_push;

  assign out_valid = (count != '0);
  assign pop = out_valid && out_ready;
  assign n_push = {1'b0, push.push0} + {1'b0, push.push1};
  assign head = mem[rd_ptr];
  assign stat.count = count;
  // Room for the two results one byte can cause.
  assign stat.room = (count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_ptr] <= data0;
    if (push.push1) mem[QUEUE_AW'(wr_ptr + 1'b1)] <= data1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= QUEUE_AW'(wr_ptr + QUEUE_AW'(n_push));
      if (pop) rd_ptr <= QUEUE_AW'(rd_ptr + 1'b1);
      count <= (QUEUE_AW+1)'(count + (QUEUE_AW+1)'(n_push) - (QUEUE_AW+1)'(pop));
    end
  end

endmodule
